// ----- rtl/hrld_pkg.sv -----
package hrld_pkg;

   localparam int unsigned METHOD_LIMIT_W = 8;
   localparam int unsigned PATH_LIMIT_W   = 16;
   localparam int unsigned CSR_DATA_W     = 16;
   localparam int unsigned CSR_INDEX_W    = 1;

   localparam logic [METHOD_LIMIT_W-1:0] METHOD_LIMIT_RST = 8'd32;
   localparam logic [PATH_LIMIT_W-1:0]   PATH_LIMIT_RST   = 16'd1024;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_METHOD_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATH_LIMIT   = 1'd1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_Z     = 8'h5a;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;

   typedef enum logic [1:0] {
      VERDICT_PENDING  = 2'd0,
      VERDICT_DETECTED = 2'd1,
      VERDICT_FAILED   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } item_type;

endpackage

// ----- rtl/hrld_req_if.sv -----
interface hrld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// ----- rtl/hrld_rsp_if.sv -----
interface hrld_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

// ----- rtl/http_request_line_detector.sv -----
// HTTP/1.x request line detector. Each transfer on req_ch carries one stream byte and
// a start flag (start_req=1 begins a new detection with this byte; after reset a
// detection is already open). For every byte exactly one verdict comes back on
// rsp_ch: 0 need more data, 1 request line detected, 2 failed; a settled verdict
// repeats until the next start. Throughput is one byte per clock with both sides
// ready; each byte passes through the input holding register and then the result
// register, with the byte compare and counter update between them. The
// method and path length limits are set through the csr_ port (index 0 method
// limit, reset 32; index 1 path limit, reset 1024) and should be written only
// while no byte is in flight.
module http_request_line_detector (
   input  logic                                clock,
   input  logic                                reset,
   hrld_req_if.sink                            req_ch,
   hrld_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [hrld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hrld_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [hrld_pkg::METHOD_LIMIT_W-1:0] method_limit_ff;
   logic [hrld_pkg::PATH_LIMIT_W-1:0]   path_limit_ff;
   logic                                item_valid;
   hrld_pkg::item_type                  item;
   logic                                advance;
   logic                                fire;
   logic                                rsp_valid_ff, rsp_valid_in;
   hrld_pkg::verdict_type               verdict;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_limit_ff <= hrld_pkg::METHOD_LIMIT_RST;
         path_limit_ff   <= hrld_pkg::PATH_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            hrld_pkg::CSR_METHOD_LIMIT:
               method_limit_ff <= csr_wdata[hrld_pkg::METHOD_LIMIT_W-1:0];
            hrld_pkg::CSR_PATH_LIMIT:
               path_limit_ff <= csr_wdata[hrld_pkg::PATH_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // result register takes a new verdict when empty or being drained
   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign fire    = item_valid && advance;

   hrld_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   hrld_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item),
      .method_limit (method_limit_ff),
      .path_limit   (path_limit_ff),
      .verdict      (verdict)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.verdict = verdict;

endmodule

// ----- rtl/hrld_in_reg.sv -----
module hrld_in_reg (
   input  logic                clock,
   input  logic                reset,
   hrld_req_if.sink            req_ch,
   input  logic                take,
   output logic                item_valid,
   output hrld_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   hrld_pkg::item_type item_ff;
   logic               load;

   // holding register frees up in the same cycle its item moves on
   assign req_ch.ready = !valid_ff || take;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte <= req_ch.data_byte;
         item_ff.start_req <= req_ch.start_req;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/hrld_eval.sv -----
module hrld_eval (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       fire,
   input  hrld_pkg::item_type                         item,
   input  logic [hrld_pkg::METHOD_LIMIT_W-1:0]        method_limit,
   input  logic [hrld_pkg::PATH_LIMIT_W-1:0]          path_limit,
   output hrld_pkg::verdict_type                      verdict
);

   typedef enum logic [3:0] {
      PH_METHOD = 4'd0,
      PH_PATH   = 4'd1,
      PH_H      = 4'd2,
      PH_HT     = 4'd3,
      PH_HTT    = 4'd4,
      PH_HTTP   = 4'd5,
      PH_SLASH  = 4'd6,
      PH_MAJOR  = 4'd7,
      PH_DOT    = 4'd8,
      PH_MINOR  = 4'd9,
      PH_EOL    = 4'd10
   } phase_type;

   phase_type                              phase_ff, phase_in, ph_cur;
   logic [hrld_pkg::METHOD_LIMIT_W-1:0]    method_count_ff, method_count_in, mc_cur;
   logic [hrld_pkg::PATH_LIMIT_W-1:0]      path_count_ff, path_count_in, pc_cur;
   hrld_pkg::verdict_type                  final_ff, final_in, fv_cur;
   hrld_pkg::verdict_type                  verdict_ff;
   logic [7:0]                             b;
   logic [7:0]                             lit;

   assign b = item.data_byte;

   always_comb begin
      // a start clears the detection before the byte is examined
      ph_cur = item.start_req ? PH_METHOD : phase_ff;
      mc_cur = item.start_req ? '0 : method_count_ff;
      pc_cur = item.start_req ? '0 : path_count_ff;
      fv_cur = item.start_req ? hrld_pkg::VERDICT_PENDING : final_ff;

      phase_in        = ph_cur;
      method_count_in = mc_cur;
      path_count_in   = pc_cur;
      final_in        = fv_cur;

      case (ph_cur)
         PH_H:     lit = hrld_pkg::CHAR_H;
         PH_HT:    lit = hrld_pkg::CHAR_T;
         PH_HTT:   lit = hrld_pkg::CHAR_T;
         PH_HTTP:  lit = hrld_pkg::CHAR_P;
         PH_SLASH: lit = hrld_pkg::CHAR_SLASH;
         PH_MAJOR: lit = hrld_pkg::CHAR_ONE;
         default:  lit = hrld_pkg::CHAR_DOT;
      endcase

      if (fv_cur == hrld_pkg::VERDICT_PENDING) begin
         case (ph_cur)
            PH_METHOD: begin
               if (b == hrld_pkg::CHAR_SPACE) begin
                  if (mc_cur == '0) begin
                     final_in = hrld_pkg::VERDICT_FAILED;
                  end else begin
                     phase_in = PH_PATH;
                  end
               end else if (b >= hrld_pkg::CHAR_A && b <= hrld_pkg::CHAR_Z) begin
                  if (mc_cur >= method_limit) begin
                     final_in = hrld_pkg::VERDICT_FAILED;
                  end else begin
                     method_count_in = mc_cur + 8'd1;
                  end
               end else begin
                  final_in = hrld_pkg::VERDICT_FAILED;
               end
            end
            PH_PATH: begin
               if (b == hrld_pkg::CHAR_SPACE) begin
                  phase_in = PH_H;
               end else if (pc_cur >= path_limit) begin
                  final_in = hrld_pkg::VERDICT_FAILED;
               end else begin
                  path_count_in = pc_cur + 16'd1;
               end
            end
            PH_H, PH_HT, PH_HTT, PH_HTTP, PH_SLASH, PH_MAJOR, PH_DOT: begin
               if (b != lit) begin
                  final_in = hrld_pkg::VERDICT_FAILED;
               end else begin
                  phase_in = phase_type'(ph_cur + 4'd1);
               end
            end
            PH_MINOR: begin
               if (b == hrld_pkg::CHAR_ZERO || b == hrld_pkg::CHAR_ONE) begin
                  phase_in = PH_EOL;
               end else begin
                  final_in = hrld_pkg::VERDICT_FAILED;
               end
            end
            PH_EOL: begin
               if (b == hrld_pkg::CHAR_CR || b == hrld_pkg::CHAR_LF) begin
                  final_in = hrld_pkg::VERDICT_DETECTED;
               end else begin
                  final_in = hrld_pkg::VERDICT_FAILED;
               end
            end
            default: begin
               final_in = hrld_pkg::VERDICT_FAILED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_METHOD;
         method_count_ff <= '0;
         path_count_ff   <= '0;
         final_ff        <= hrld_pkg::VERDICT_PENDING;
      end else if (fire) begin
         phase_ff        <= phase_in;
         method_count_ff <= method_count_in;
         path_count_ff   <= path_count_in;
         final_ff        <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         verdict_ff <= final_in;
      end
   end

   assign verdict = verdict_ff;

   // a settled verdict holds until the next start
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      fire && !item.start_req && final_ff != hrld_pkg::VERDICT_PENDING
      |=> final_ff == $past(final_ff))
      else $error("settled verdict changed without a start");

   a_method_frozen: assert property (@(posedge clock) disable iff (reset)
      fire && !item.start_req && phase_ff != PH_METHOD
      |=> method_count_ff == $past(method_count_ff))
      else $error("method count moved outside the method phase");

   a_detect_from_eol: assert property (@(posedge clock) disable iff (reset)
      fire && !item.start_req && final_ff == hrld_pkg::VERDICT_PENDING && phase_ff != PH_EOL
      |=> final_ff != hrld_pkg::VERDICT_DETECTED)
      else $error("detection reported before the line end");

endmodule

// ----- tb/tb_http_request_line_detector.sv -----
module tb_http_request_line_detector;

   typedef enum logic [3:0] {
      POS_METHOD, POS_PATH, POS_H, POS_HT, POS_HTT, POS_HTTP,
      POS_SLASH, POS_MAJOR, POS_DOT, POS_MINOR, POS_EOL
   } line_pos_type;

   // Tracks the detection state and queues the verdict each transfer must produce.
   class verdict_board;
      logic [hrld_pkg::METHOD_LIMIT_W-1:0] method_lim;
      logic [hrld_pkg::PATH_LIMIT_W-1:0]   path_lim;
      line_pos_type                        pos;
      logic [7:0]                          method_cnt;
      logic [15:0]                         path_cnt;
      hrld_pkg::verdict_type               sticky;
      hrld_pkg::verdict_type               expected_q[$];
      int                                  fails;

      function new();
         method_lim = hrld_pkg::METHOD_LIMIT_RST;
         path_lim   = hrld_pkg::PATH_LIMIT_RST;
         fails      = 0;
         clear_line();
      endfunction

      function void clear_line();
         pos        = POS_METHOD;
         method_cnt = '0;
         path_cnt   = '0;
         sticky     = hrld_pkg::VERDICT_PENDING;
      endfunction

      function void set_limit(logic [hrld_pkg::CSR_INDEX_W-1:0] idx,
                              logic [hrld_pkg::CSR_DATA_W-1:0] val);
         if (idx == hrld_pkg::CSR_METHOD_LIMIT) begin
            method_lim = val[hrld_pkg::METHOD_LIMIT_W-1:0];
         end else if (idx == hrld_pkg::CSR_PATH_LIMIT) begin
            path_lim = val[hrld_pkg::PATH_LIMIT_W-1:0];
         end
      endfunction

      function logic [7:0] version_char(line_pos_type p);
         case (p)
            POS_H:     return hrld_pkg::CHAR_H;
            POS_HT:    return hrld_pkg::CHAR_T;
            POS_HTT:   return hrld_pkg::CHAR_T;
            POS_HTTP:  return hrld_pkg::CHAR_P;
            POS_SLASH: return hrld_pkg::CHAR_SLASH;
            POS_MAJOR: return hrld_pkg::CHAR_ONE;
            default:   return hrld_pkg::CHAR_DOT;
         endcase
      endfunction

      function hrld_pkg::verdict_type judge(logic [7:0] b);
         hrld_pkg::verdict_type v;
         v = hrld_pkg::VERDICT_FAILED;
         case (pos)
            POS_METHOD: begin
               if (b == hrld_pkg::CHAR_SPACE) begin
                  if (method_cnt != 0) begin
                     pos = POS_PATH;
                     v   = hrld_pkg::VERDICT_PENDING;
                  end
               end else if (b >= hrld_pkg::CHAR_A && b <= hrld_pkg::CHAR_Z &&
                            method_cnt < method_lim) begin
                  method_cnt = method_cnt + 8'd1;
                  v          = hrld_pkg::VERDICT_PENDING;
               end
            end
            POS_PATH: begin
               if (b == hrld_pkg::CHAR_SPACE) begin
                  pos = POS_H;
                  v   = hrld_pkg::VERDICT_PENDING;
               end else if (path_cnt < path_lim) begin
                  path_cnt = path_cnt + 16'd1;
                  v        = hrld_pkg::VERDICT_PENDING;
               end
            end
            POS_H, POS_HT, POS_HTT, POS_HTTP, POS_SLASH, POS_MAJOR, POS_DOT: begin
               if (b == version_char(pos)) begin
                  pos = line_pos_type'(pos + 4'd1);
                  v   = hrld_pkg::VERDICT_PENDING;
               end
            end
            POS_MINOR: begin
               if (b == hrld_pkg::CHAR_ZERO || b == hrld_pkg::CHAR_ONE) begin
                  pos = POS_EOL;
                  v   = hrld_pkg::VERDICT_PENDING;
               end
            end
            POS_EOL: begin
               if (b == hrld_pkg::CHAR_CR || b == hrld_pkg::CHAR_LF) begin
                  v = hrld_pkg::VERDICT_DETECTED;
               end
            end
            default: ;
         endcase
         return v;
      endfunction

      function void note_byte(logic [7:0] b, logic st);
         if (st) clear_line();
         if (sticky == hrld_pkg::VERDICT_PENDING) sticky = judge(b);
         expected_q.push_back(sticky);
      endfunction

      function void check_verdict(logic [1:0] got);
         hrld_pkg::verdict_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: verdict with nothing expected: expected none, actual %0d",
                     $time, got);
            fails++;
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            $display("%0t: verdict mismatch: expected %0d, actual %0d", $time, want, got);
            fails++;
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               csr_wr_en;
   logic [hrld_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [hrld_pkg::CSR_DATA_W-1:0]    csr_wdata;

   hrld_req_if req_ch ();
   hrld_rsp_if rsp_ch ();

   http_request_line_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   verdict_board board;
   int           burst_left;
   int           accepted_items;
   bit           long_hold_req;
   logic [7:0]   line_q[$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // receiver: alternates between always-ready, random and mostly-stalled modes
   initial begin
      int hold_cycles;
      int mode;
      int mode_left;
      hold_cycles = 0;
      mode        = 0;
      mode_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cycles   = 300;
         end
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(2, 0);
               mode_left = $urandom_range(200, 10);
            end
            mode_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(3, 0) != 0);
               default: rsp_ch.ready <= ($urandom_range(3, 0) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_verdict(rsp_ch.verdict);
   end

   task automatic send_byte(logic [7:0] b, logic st);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(30, 1);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.start_req <= st;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_byte(b, st);
      accepted_items++;
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_text(string s, logic st);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], (i == 0) ? st : 1'b0);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(logic [hrld_pkg::CSR_INDEX_W-1:0] idx,
                            logic [hrld_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_limit(idx, val);
      @(negedge clock);
   endtask

   function automatic int pick_len(int lim, int cap);
      int n;
      n = $urandom_range((lim < cap) ? lim : cap, 1);
      // land on the limit or one past it now and then
      if (lim <= 64 && $urandom_range(5, 0) == 0) n = lim + $urandom_range(1, 0);
      return n;
   endfunction

   task automatic send_line();
      int         kind;
      int         n;
      int         cut;
      logic [7:0] b;
      logic       st;
      string      ver;
      line_q.delete();
      kind = $urandom_range(9, 0);
      if (kind >= 8) begin
         repeat ($urandom_range(6, 1)) line_q.push_back(8'($urandom_range(255, 0)));
      end else begin
         n = pick_len(board.method_lim, 8);
         repeat (n) line_q.push_back(8'($urandom_range(hrld_pkg::CHAR_Z, hrld_pkg::CHAR_A)));
         line_q.push_back(hrld_pkg::CHAR_SPACE);
         n = pick_len(board.path_lim, 12);
         if ($urandom_range(7, 0) == 0) n = 0;
         repeat (n) begin
            do b = 8'($urandom_range(255, 0)); while (b == hrld_pkg::CHAR_SPACE);
            line_q.push_back(b);
         end
         ver = " HTTP/1.";
         for (int i = 0; i < ver.len(); i++) line_q.push_back(ver[i]);
         line_q.push_back($urandom_range(1, 0) ? hrld_pkg::CHAR_ONE : hrld_pkg::CHAR_ZERO);
         line_q.push_back($urandom_range(1, 0) ? hrld_pkg::CHAR_CR : hrld_pkg::CHAR_LF);
         cut = $urandom_range(line_q.size() - 1, 0);
         if (kind == 6) line_q[cut] = 8'($urandom_range(255, 0));
         if (kind == 7) line_q = line_q[0:cut];
      end
      // trailing bytes after a settled verdict
      if ($urandom_range(3, 0) == 0) begin
         repeat ($urandom_range(3, 1)) line_q.push_back(8'($urandom_range(255, 0)));
      end
      st = ($urandom_range(7, 0) != 0);
      for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], (i == 0) ? st : 1'b0);
   endtask

   initial begin
      logic [hrld_pkg::CSR_DATA_W-1:0] method_set[5];
      logic [hrld_pkg::CSR_DATA_W-1:0] path_set[5];
      int                              phase_start;
      board          = new();
      burst_left     = 0;
      accepted_items = 0;
      long_hold_req  = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.start_req = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(hrld_pkg::CSR_METHOD_LIMIT, 16'd1);
      write_reg(hrld_pkg::CSR_PATH_LIMIT, 16'd1);
      // fresh detection without start, then bytes after a verdict
      send_text("A / HTTP/1.0\n", 1'b0);
      send_byte(8'hff, 1'b0);
      send_text(" ", 1'b1);       // empty method
      send_text("AB", 1'b1);      // method over limit
      send_text("A /x", 1'b1);    // path over limit
      send_text("@", 1'b1);       // non-letter in method
      send_byte(8'h00, 1'b1);
      wait_idle();

      method_set = '{16'd1, 16'd255, 16'd32, 16'($urandom_range(10, 2)),
                     16'($urandom_range(255, 1))};
      path_set   = '{16'd1, 16'd65535, 16'd1024, 16'($urandom_range(20, 2)),
                     16'($urandom_range(300, 1))};
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(hrld_pkg::CSR_METHOD_LIMIT, method_set[ph]);
         write_reg(hrld_pkg::CSR_PATH_LIMIT, path_set[ph]);
         // long receiver stall while bytes keep coming
         if (ph == 2) long_hold_req = 1'b1;
         phase_start = accepted_items;
         while (accepted_items - phase_start < 210) send_line();
         wait_idle();
      end

      repeat (10) @(negedge clock);
      if (board.fails == 0 && board.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
